// ===== sv/aril_pkg.sv =====
// package: widths, item types and request codes for the address range index lookup
package aril_pkg;

  // default table depth
  localparam int ARIL_TABLE_DEPTH = 1024;

  // field widths
  localparam int ARIL_COUNT_W  = 11;
  localparam int ARIL_SLOT_W   = 10;
  localparam int ARIL_START_W  = 64;
  localparam int ARIL_INDEX_W  = 32;
  localparam int ARIL_ENTRY_W  = ARIL_START_W + ARIL_INDEX_W;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // input item
  typedef struct packed {
    logic                    req_type;
    logic [ARIL_SLOT_W-1:0]  entry_slot;
    logic [ARIL_START_W-1:0] entry_start;
    logic [ARIL_INDEX_W-1:0] entry_index;
    logic [ARIL_START_W-1:0] query_offset;
  } req_item_t;

  // result item
  typedef struct packed {
    logic [ARIL_INDEX_W-1:0] result_index;
    logic                    in_range;
  } rsp_item_t;

endpackage

// ===== sv/aril_ifs.sv =====
// interfaces: request and response channels with valid/ready handshake
interface aril_req_if import aril_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface aril_rsp_if import aril_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== sv/aril_ram.sv =====
// generic single-port ram with registered read
module aril_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/address_range_index_lookup_unit.sv =====
// top level: sorted range table in ram with a binary search sequencer
//
//  channel   dir   handshake            payload
//  req       in    req.valid/req.ready  req_type, entry_slot, entry_start,
//                                       entry_index, query_offset
//  rsp       out   rsp.valid/rsp.ready  result_index, in_range
//  cfg       in    cfg_we               cfg_wdata (table_count)
//
// a load item writes the table ram in its accept cycle
// a query item reads the first and last entries as bounds; when the offset lies between
// them it does one ram read per search step (at most clog2(TABLE_DEPTH)), then posts the result
// the single ram port sets the pace: one search step per cycle
// rst clears the sequencer, table_count and the result valid; the ram is not cleared
// req.ready is high only while idle; a held result stalls the sequencer in its last state
module address_range_index_lookup_unit
  import aril_pkg::*;
#(
  parameter int TABLE_DEPTH = ARIL_TABLE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  aril_req_if.sink                req,
  aril_rsp_if.source              rsp,
  input  logic                    cfg_we,
  input  logic [ARIL_COUNT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]              state;
  logic [2:0]              state_next;
  logic [ARIL_COUNT_W-1:0] table_count;
  logic [CW-1:0]           n_eff;
  logic [CW-1:0]           lo;
  logic [CW-1:0]           lo_next;
  logic [CW-1:0]           hi;
  logic [CW-1:0]           hi_next;
  logic [CW:0]             mid_sum;
  logic [ARIL_INDEX_W-1:0] lo_idx;
  logic [ARIL_INDEX_W-1:0] lo_idx_next;
  logic [ARIL_START_W-1:0] qoff;
  logic                    first_ok;
  logic [ARIL_INDEX_W-1:0] res_index;
  logic                    res_hit;
  logic                    res_load;
  logic [ARIL_INDEX_W-1:0] res_index_next;
  logic                    res_hit_next;
  logic [ARIL_INDEX_W-1:0] out_index;
  logic                    out_hit;
  logic                    out_valid;
  logic                    out_free;

  logic                    ram_we;
  logic [AW-1:0]           ram_addr;
  logic [ARIL_ENTRY_W-1:0] ram_wdata;
  logic [ARIL_ENTRY_W-1:0] ram_rdata;
  logic [ARIL_START_W-1:0] rd_start;
  logic [ARIL_INDEX_W-1:0] rd_index;
  logic                    accept;
  logic                    is_query;
  logic                    slot_ok;

  // table ram: start offset above index
  aril_ram #(
    .WIDTH (ARIL_ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_start = ram_rdata[ARIL_ENTRY_W-1:ARIL_INDEX_W];
  assign rd_index = ram_rdata[ARIL_INDEX_W-1:0];

  // input handshake
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign is_query  = (req.item.req_type == REQ_QUERY);
  assign slot_ok   = (32'(req.item.entry_slot) < TABLE_DEPTH);
  assign ram_we    = accept && !is_query && slot_ok;
  assign ram_wdata = {req.item.entry_start, req.item.entry_index};

  // count saturates at the table depth
  assign n_eff = (32'(table_count) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(table_count);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= '0;
    end else if (cfg_we) begin
      table_count <= cfg_wdata;
    end
  end

  // search step, address select and next state
  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    lo_idx_next    = lo_idx;
    res_load       = 1'b0;
    res_index_next = '0;
    res_hit_next   = 1'b0;
    mid_sum        = '0;
    ram_addr       = '0;
    case (state)
      S_IDLE: begin
        ram_addr = AW'(req.item.entry_slot);
        if (accept && is_query) begin
          ram_addr   = '0;
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        lo_idx_next = rd_index;
        ram_addr    = (n_eff == '0) ? '0 : AW'(n_eff - CW'(1));
        state_next  = S_LAST;
      end
      S_LAST: begin
        if (first_ok && (qoff < rd_start)) begin
          mid_sum    = ({1'b0, lo} + {1'b0, hi}) >> 1;
          ram_addr   = AW'(mid_sum);
          state_next = S_SRCH;
        end else begin
          res_load   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SRCH: begin
        mid_sum = ({1'b0, lo} + {1'b0, hi}) >> 1;
        if (rd_start > qoff) begin
          hi_next = CW'(mid_sum);
        end else begin
          lo_next     = CW'(mid_sum);
          lo_idx_next = rd_index;
        end
        if ((rd_start == qoff) || ((hi_next - lo_next) <= CW'(1))) begin
          res_load       = 1'b1;
          res_index_next = lo_idx_next;
          res_hit_next   = 1'b1;
          state_next     = S_DONE;
        end else begin
          ram_addr = AW'(({1'b0, lo_next} + {1'b0, hi_next}) >> 1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      qoff <= req.item.query_offset;
      lo   <= '0;
      hi   <= n_eff;
    end else begin
      lo <= lo_next;
      hi <= hi_next;
    end
    lo_idx <= lo_idx_next;
    if (state == S_FIRST) begin
      first_ok <= (n_eff != '0) && (rd_start <= qoff);
    end
    if (res_load) begin
      res_index <= res_index_next;
      res_hit   <= res_hit_next;
    end
  end

  // output register
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_index <= res_index;
      out_hit   <= res_hit;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.item.result_index = out_index;
  assign rsp.item.in_range     = out_hit;

endmodule

// ===== test/address_range_index_lookup_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench: range table loads and offset lookups, checked against a shadow table search
module address_range_index_lookup_unit_tb import aril_pkg::*; ();

  localparam int DEPTH    = ARIL_TABLE_DEPTH;
  localparam int IDLE_PCT = 27;

  // kinds of row in the directed table
  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [ARIL_COUNT_W-1:0] count;
    logic [ARIL_SLOT_W-1:0]  slot;
    logic [ARIL_START_W-1:0] value;
    logic [ARIL_INDEX_W-1:0] index;
    logic                    fixed;
    rsp_item_t               want;
  } dir_row_t;

  // directed part: value is the start for a load, the offset for a query
  localparam dir_row_t DIRECTED [22] = '{
    // empty table after reset
    '{ROW_QUERY, 11'd0, 10'd0,    64'h0,                  32'h0,        1'b1, '{32'h0, 1'b0}},
    '{ROW_QUERY, 11'd0, 10'd0,    64'hFFFF_FFFF_FFFF_FFFF, 32'h0,       1'b1, '{32'h0, 1'b0}},
    // small sorted table spanning the offset extremes
    '{ROW_LOAD,  11'd0, 10'd0,    64'h0,                  32'h1111_1111, 1'b0, '{32'h0, 1'b0}},
    '{ROW_LOAD,  11'd0, 10'd1,    64'h100,                32'h2222_2222, 1'b0, '{32'h0, 1'b0}},
    '{ROW_LOAD,  11'd0, 10'd2,    64'h8000_0000_0000_0000, 32'h3333_3333, 1'b0, '{32'h0, 1'b0}},
    '{ROW_LOAD,  11'd0, 10'd3,    64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '{32'h0, 1'b0}},
    '{ROW_LOAD,  11'd0, 10'd1023, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0, '{32'h0, 1'b0}},
    // single entry: never in range
    '{ROW_CFG,   11'd1, 10'd0,    64'h0,                  32'h0,        1'b0, '{32'h0, 1'b0}},
    '{ROW_QUERY, 11'd0, 10'd0,    64'h0,                  32'h0,        1'b1, '{32'h0, 1'b0}},
    '{ROW_CFG,   11'd4, 10'd0,    64'h0,                  32'h0,        1'b0, '{32'h0, 1'b0}},
    '{ROW_QUERY, 11'd0, 10'd0,    64'h0,                  32'h0,        1'b0, '{32'h0, 1'b0}},
    '{ROW_QUERY, 11'd0, 10'd0,    64'h100,                32'h0,        1'b0, '{32'h0, 1'b0}},
    '{ROW_QUERY, 11'd0, 10'd0,    64'hFF,                 32'h0,        1'b0, '{32'h0, 1'b0}},
    '{ROW_QUERY, 11'd0, 10'd0,    64'h8000_0000_0000_0000, 32'h0,       1'b0, '{32'h0, 1'b0}},
    '{ROW_QUERY, 11'd0, 10'd0,    64'hFFFF_FFFF_FFFF_FFFE, 32'h0,       1'b0, '{32'h0, 1'b0}},
    // offset equal to the last start lies outside
    '{ROW_QUERY, 11'd0, 10'd0,    64'hFFFF_FFFF_FFFF_FFFF, 32'h0,       1'b1, '{32'h0, 1'b0}},
    // break the ordering: the search still runs
    '{ROW_LOAD,  11'd0, 10'd2,    64'h50,                 32'h4444_4444, 1'b0, '{32'h0, 1'b0}},
    '{ROW_QUERY, 11'd0, 10'd0,    64'h60,                 32'h0,        1'b0, '{32'h0, 1'b0}},
    '{ROW_QUERY, 11'd0, 10'd0,    64'h20,                 32'h0,        1'b0, '{32'h0, 1'b0}},
    // count back to zero over a written table
    '{ROW_CFG,   11'd0, 10'd0,    64'h0,                  32'h0,        1'b0, '{32'h0, 1'b0}},
    '{ROW_QUERY, 11'd0, 10'd0,    64'h10,                 32'h0,        1'b1, '{32'h0, 1'b0}},
    '{ROW_QUERY, 11'd0, 10'd0,    64'h0,                  32'h0,        1'b1, '{32'h0, 1'b0}}
  };

  localparam int SMALL_COUNTS [10] = '{2, 3, 1, 0, 17, 5, 40, 9, 31, 8};

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_we;
  logic [ARIL_COUNT_W-1:0] cfg_wdata;

  aril_req_if req_ch ();
  aril_rsp_if rsp_ch ();

  address_range_index_lookup_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the table, the count and the lookups in flight
  logic [ARIL_START_W-1:0] start_shadow [DEPTH];
  logic [ARIL_INDEX_W-1:0] index_shadow [DEPTH];
  logic [ARIL_COUNT_W-1:0] shadow_count = '0;
  rsp_item_t               expected_lookups [$];
  int                      mismatch_count = 0;
  bit                      calm = 1'b0;

  always #10 clk = ~clk;

  // counts above the depth saturate
  function automatic int unsigned eff_count();
    return (shadow_count > DEPTH) ? DEPTH : shadow_count;
  endfunction

  // binary search over the shadow table
  function automatic rsp_item_t lookup_range(input logic [ARIL_START_W-1:0] off);
    int unsigned n, lo, hi, mid;
    bit          done;
    rsp_item_t   r;
    n = eff_count();
    r = '0;
    if (n != 0 && start_shadow[0] <= off && off < start_shadow[n-1]) begin
      lo   = 0;
      hi   = n;
      done = 1'b0;
      while (!done) begin
        mid = (lo + hi) / 2;
        if (start_shadow[mid] < off) lo = mid;
        else if (start_shadow[mid] > off) hi = mid;
        else begin
          lo   = mid;
          done = 1'b1;
        end
        if (hi - lo <= 1) done = 1'b1;
      end
      r.result_index = index_shadow[lo];
      r.in_range     = 1'b1;
    end
    return r;
  endfunction

  // unused fields carry random bits
  function automatic req_item_t make_load(input logic [ARIL_SLOT_W-1:0] slot,
                                          input logic [ARIL_START_W-1:0] start,
                                          input logic [ARIL_INDEX_W-1:0] index);
    req_item_t it;
    it.req_type     = REQ_LOAD;
    it.entry_slot   = slot;
    it.entry_start  = start;
    it.entry_index  = index;
    it.query_offset = {$urandom, $urandom};
    return it;
  endfunction

  function automatic req_item_t make_query(input logic [ARIL_START_W-1:0] off);
    req_item_t it;
    it.req_type     = REQ_QUERY;
    it.entry_slot   = ARIL_SLOT_W'($urandom);
    it.entry_start  = {$urandom, $urandom};
    it.entry_index  = $urandom;
    it.query_offset = off;
    return it;
  endfunction

  // offsets aimed at entry starts, their neighbours and the boundaries
  function automatic logic [ARIL_START_W-1:0] pick_offset();
    int unsigned             n, k;
    logic [ARIL_START_W-1:0] off;
    n   = eff_count();
    off = {$urandom, $urandom};
    if (n != 0) begin
      k = $urandom_range(n - 1);
      case ($urandom_range(9))
        0: ;
        1: off = $urandom_range(1) ? '1 : '0;
        2, 3, 4: off = start_shadow[k];
        5, 6: off = start_shadow[k] + $urandom_range(3, 1);
        7: off = start_shadow[k] + $urandom;
        8: off = start_shadow[k] - 1;
        default: off = $urandom_range(1) ? start_shadow[n-1] : start_shadow[0];
      endcase
    end
    return off;
  endfunction

  // present one item, update the shadow table or queue the lookup on acceptance
  task automatic send_item(input req_item_t it, input bit fixed, input rsp_item_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.item  <= it;
    do @(posedge clk); while (!req_ch.ready);
    if (it.req_type == REQ_LOAD) begin
      start_shadow[it.entry_slot] = it.entry_start;
      index_shadow[it.entry_slot] = it.entry_index;
    end else begin
      expected_lookups.push_back(fixed ? want : lookup_range(it.query_offset));
    end
  endtask

  // count is written only once the block has drained
  task automatic set_count(input logic [ARIL_COUNT_W-1:0] n);
    req_ch.valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we       <= 1'b0;
    shadow_count  = n;
  endtask

  // fill slots from zero upwards, ascending starts unless told otherwise
  task automatic load_table(input int n, input bit sorted);
    logic [ARIL_START_W-1:0] cur;
    logic [ARIL_START_W-1:0] step;
    cur = {$urandom, $urandom} >> $urandom_range(63, 0);
    for (int k = 0; k < n; k++) begin
      send_item(make_load(ARIL_SLOT_W'(k), sorted ? cur : {$urandom, $urandom}, $urandom),
                1'b0, '0);
      step = ($urandom_range(3) == 0) ? ({$urandom, $urandom} >> $urandom_range(63, 40))
                                      : 64'($urandom_range(16, 1));
      cur += step;
    end
  endtask

  // mostly lookups, with stray loads to any slot
  task automatic mixed_traffic(input int ops, input int load_pct);
    for (int i = 0; i < ops; i++) begin
      if ($urandom_range(99) < load_pct)
        send_item(make_load(ARIL_SLOT_W'($urandom), {$urandom, $urandom}, $urandom), 1'b0, '0);
      else
        send_item(make_query(pick_offset()), 1'b0, '0);
    end
  endtask

  // stimulus
  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_ch.valid = 1'b0;
    req_ch.item  = '0;
    rsp_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    foreach (DIRECTED[i]) begin
      case (DIRECTED[i].kind)
        ROW_CFG:  set_count(DIRECTED[i].count);
        ROW_LOAD: send_item(make_load(DIRECTED[i].slot, DIRECTED[i].value, DIRECTED[i].index),
                            1'b0, '0);
        default:  send_item(make_query(DIRECTED[i].value), DIRECTED[i].fixed, DIRECTED[i].want);
      endcase
    end

    // small tables, now and then unsorted
    foreach (SMALL_COUNTS[p]) begin
      set_count(ARIL_COUNT_W'(SMALL_COUNTS[p]));
      load_table(SMALL_COUNTS[p], $urandom_range(3) != 0);
      mixed_traffic(45, 10);
    end

    // full table with no idling, then the count extremes
    calm = 1'b1;
    set_count(ARIL_COUNT_W'(DEPTH));
    load_table(DEPTH, 1'b1);
    mixed_traffic(50, 0);
    calm = 1'b0;
    mixed_traffic(50, 5);
    set_count('1);
    mixed_traffic(60, 5);
    set_count(ARIL_COUNT_W'(DEPTH + 1));
    mixed_traffic(30, 5);
    set_count(ARIL_COUNT_W'(DEPTH - 1));
    mixed_traffic(30, 5);

    // drain and report
    req_ch.valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: check each accepted item, stall at random
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t unexpected result: expected none, got index %h in_range %b",
                 $time, rsp_ch.item.result_index, rsp_ch.item.in_range);
        mismatch_count++;
      end else begin
        want = expected_lookups.pop_front();
        if (rsp_ch.item.result_index !== want.result_index) begin
          $display("%0t result_index: expected %h, got %h",
                   $time, want.result_index, rsp_ch.item.result_index);
          mismatch_count++;
        end
        if (rsp_ch.item.in_range !== want.in_range) begin
          $display("%0t in_range: expected %b, got %b",
                   $time, want.in_range, rsp_ch.item.in_range);
          mismatch_count++;
        end
      end
    end
    rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
sv/aril_pkg.sv
sv/aril_ifs.sv
sv/aril_ram.sv
sv/address_range_index_lookup_unit.sv
test/address_range_index_lookup_unit_tb.sv
